// File: design/sfrgbpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial framed RGB PWM LED driver package
// Shared types, register indexes and constants for the LED driver.
// ----------------------------------------------------------------------------
package sfrgbpwm_pkg;

    localparam int LED_COUNT_DEFAULT = 12;
    localparam int COLORS_PER_LED    = 3;
    localparam int FIELD_W           = 36;
    localparam int CFG_INDEX_W       = 8;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] PREAMBLE   = 8'd0;
    localparam logic [7:0] COLOR_SAT  = 8'd255;
    localparam int         EDGE_COUNT = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_TOP    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_BOTTOM = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_LEFT   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_RIGHT  = 8'd3;

    localparam logic [7:0] BASE_TOP_RESET    = 8'd0;
    localparam logic [7:0] BASE_BOTTOM_RESET = 8'd7;
    localparam logic [7:0] BASE_LEFT_RESET   = 8'd12;
    localparam logic [7:0] BASE_RIGHT_RESET  = 8'd4;

    typedef logic [EDGE_COUNT-1:0][7:0] base_regs_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] pin_levels;
        logic [FIELD_W-1:0] changed_mask;
        logic               frame_written;
        logic               frame_dropped;
    } out_item_t;

    typedef struct packed {
        logic       written;
        logic       dropped;
        logic [7:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } frame_event_t;

    typedef enum logic [5:0] {
        PH_PREAMBLE = 6'b000001,
        PH_EDGE     = 6'b000010,
        PH_LED      = 6'b000100,
        PH_RED      = 6'b001000,
        PH_GREEN    = 6'b010000,
        PH_BLUE     = 6'b100000
    } parse_phase_t;

    function automatic logic [7:0] color_adjust(input logic [7:0] raw);
        return (raw == COLOR_SAT) ? raw : raw - 8'd1;
    endfunction

endpackage

// File: design/serial_framed_rgb_pwm_led_driver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial framed RGB PWM LED driver
// Accepts serial bytes and timer ticks, parses color frames into a duty store
// and drives three PWM channels per LED.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one transaction per received byte (op = 0) or per
// timer tick (op = 1); it is taken when in_valid is high and in_stall is low.
// Every input transaction yields exactly one output transaction carrying the
// channel levels, the channels changed by a tick and the frame status flags.
// The result is registered: it appears on out_valid in the cycle after the input
// is taken, and one transaction per cycle is sustained while out_stall is low. The
// single result register is the only register on this path; the parser and all
// duty comparators finish within the cycle of acceptance.
// When the receiver raises out_stall while a result is waiting, in_stall is
// raised in the same cycle and the waiting result holds until it is taken.
// The configuration channel writes one base register per edge; cfg_ready is
// always high; the user must make writes only while idle; it is not enforced.
// Reset clears the duties, levels, tick counter and parser, and restores the
// base registers to their defaults; the block is ready at once after reset.
// ----------------------------------------------------------------------------
module serial_framed_rgb_pwm_led_driver_top
    import sfrgbpwm_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    localparam int CHANNELS = LED_COUNT * COLORS_PER_LED;

    base_regs_t          base_reg;
    logic                accept;
    logic                byte_en;
    logic                tick_en;
    frame_event_t        frame_event;
    logic [CHANNELS-1:0] level_after;
    logic [CHANNELS-1:0] changed;
    logic [FIELD_W-1:0]  pins_shown;
    logic [FIELD_W-1:0]  changed_shown;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg[0] <= BASE_TOP_RESET;
            base_reg[1] <= BASE_BOTTOM_RESET;
            base_reg[2] <= BASE_LEFT_RESET;
            base_reg[3] <= BASE_RIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BASE_TOP:    base_reg[0] <= cfg_data;
                CFG_BASE_BOTTOM: base_reg[1] <= cfg_data;
                CFG_BASE_LEFT:   base_reg[2] <= cfg_data;
                CFG_BASE_RIGHT:  base_reg[3] <= cfg_data;
                default:         base_reg <= base_reg;
            endcase
        end
    end

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign byte_en  = accept && (in_data.op == OP_BYTE);
    assign tick_en  = accept && (in_data.op == OP_TICK);

    sfrgbpwm_parser #(
        .LED_COUNT (LED_COUNT)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_en     (byte_en),
        .rx_byte     (in_data.rx_byte),
        .base_regs   (base_reg),
        .frame_event (frame_event)
    );

    sfrgbpwm_pwm #(
        .LED_COUNT (LED_COUNT)
    ) u_pwm (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (tick_en),
        .frame_event (frame_event),
        .level_after (level_after),
        .changed     (changed)
    );

    for (genvar b = 0; b < FIELD_W; b++)
    begin : g_shown
        if (b < CHANNELS)
        begin : g_live
            assign pins_shown[b]    = level_after[b];
            assign changed_shown[b] = changed[b];
        end
        else
        begin : g_pad
            assign pins_shown[b]    = 1'b0;
            assign changed_shown[b] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.pin_levels    <= pins_shown;
            out_data_reg.changed_mask  <= changed_shown;
            out_data_reg.frame_written <= frame_event.written;
            out_data_reg.frame_dropped <= frame_event.dropped;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/sfrgbpwm_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Waits for a zero preamble, collects edge, led and three color bytes, and
// reports a completed frame with its LED index and duties.
// ----------------------------------------------------------------------------
module sfrgbpwm_parser
    import sfrgbpwm_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_en,
    input  logic [7:0]   rx_byte,
    input  base_regs_t   base_regs,
    output frame_event_t frame_event
);

    localparam logic [7:0] LED_LIMIT = 8'(LED_COUNT);

    parse_phase_t phase_reg;
    parse_phase_t phase_next;
    logic [7:0]   edge_reg;
    logic [7:0]   led_reg;
    logic [7:0]   red_reg;
    logic [7:0]   green_reg;
    logic [7:0]   led_index;
    logic         frame_done;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_PREAMBLE: phase_next = (rx_byte == PREAMBLE) ? PH_EDGE : PH_PREAMBLE;
            PH_EDGE:     phase_next = PH_LED;
            PH_LED:      phase_next = PH_RED;
            PH_RED:      phase_next = PH_GREEN;
            PH_GREEN:    phase_next = PH_BLUE;
            PH_BLUE:     phase_next = PH_PREAMBLE;
            default:     phase_next = PH_PREAMBLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREAMBLE;
        end
        else if (byte_en)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_en)
        begin
            if (phase_reg == PH_EDGE)
            begin
                edge_reg <= rx_byte - 8'd1;
            end
            if (phase_reg == PH_LED)
            begin
                led_reg <= rx_byte - 8'd1;
            end
            if (phase_reg == PH_RED)
            begin
                red_reg <= color_adjust(rx_byte);
            end
            if (phase_reg == PH_GREEN)
            begin
                green_reg <= color_adjust(rx_byte);
            end
        end
    end

    always_comb
    begin
        if (edge_reg < 8'(EDGE_COUNT))
        begin
            led_index = base_regs[edge_reg[1:0]] + led_reg;
        end
        else
        begin
            led_index = 8'd0;
        end
    end

    assign frame_done = byte_en && (phase_reg == PH_BLUE);

    assign frame_event.written = frame_done && (led_index < LED_LIMIT);
    assign frame_event.dropped = frame_done && !(led_index < LED_LIMIT);
    assign frame_event.led     = led_index;
    assign frame_event.red     = red_reg;
    assign frame_event.green   = green_reg;
    assign frame_event.blue    = color_adjust(rx_byte);

endmodule

// File: design/sfrgbpwm_pwm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM channel bank
// Holds the duty of every channel, the tick counter and the channel levels,
// and compares all duties against the counter on each tick.
// ----------------------------------------------------------------------------
module sfrgbpwm_pwm
    import sfrgbpwm_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tick_en,
    input  frame_event_t                       frame_event,
    output logic [LED_COUNT*COLORS_PER_LED-1:0] level_after,
    output logic [LED_COUNT*COLORS_PER_LED-1:0] changed
);

    localparam int CHANNELS = LED_COUNT * COLORS_PER_LED;

    logic [7:0]          duty_reg [CHANNELS];
    logic [CHANNELS-1:0] level_reg;
    logic [CHANNELS-1:0] level_next;
    logic [7:0]          tick_reg;

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            level_next[ch] = (duty_reg[ch] <= tick_reg);
        end
    end

    assign level_after = tick_en ? level_next : level_reg;
    assign changed     = tick_en ? (level_next ^ level_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            tick_reg  <= 8'd0;
        end
        else if (tick_en)
        begin
            level_reg <= level_next;
            tick_reg  <= tick_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                duty_reg[ch] <= 8'd0;
            end
        end
        else
        begin
            for (int l = 0; l < LED_COUNT; l++)
            begin
                if (frame_event.written && (frame_event.led == 8'(l)))
                begin
                    duty_reg[COLORS_PER_LED*l]     <= frame_event.red;
                    duty_reg[COLORS_PER_LED*l + 1] <= frame_event.green;
                    duty_reg[COLORS_PER_LED*l + 2] <= frame_event.blue;
                end
            end
        end
    end

endmodule

// File: sim/tb_serial_framed_rgb_pwm_led_driver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial framed RGB PWM LED driver testbench
// Sends serial bytes and timer ticks through the input channel, predicts
// every output transaction from an internal copy of the frame parser, the
// duty store and the channel levels, and checks each field in order.
// The testbench runs with random idle bursts on both sides, a long receiver
// hold-off, and several edge base settings, including all zero and all ones.
// ----------------------------------------------------------------------------
module tb_serial_framed_rgb_pwm_led_driver_top;
    import sfrgbpwm_pkg::*;

    localparam int LED_COUNT      = LED_COUNT_DEFAULT;
    localparam int CHANNELS       = LED_COUNT * COLORS_PER_LED;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 230;
    localparam int PHASE_COUNT    = 6;

    localparam logic [CFG_INDEX_W-1:0] BASE_REG [EDGE_COUNT] =
        '{CFG_BASE_TOP, CFG_BASE_BOTTOM, CFG_BASE_LEFT, CFG_BASE_RIGHT};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data = '0;

    in_item_t     pending_q [$];
    out_item_t    expected_led_q [$];

    logic [7:0]   edge_base [EDGE_COUNT];
    logic [7:0]   tick_cnt;
    logic [7:0]   duty_mem [CHANNELS];
    logic         level_mem [CHANNELS];
    parse_phase_t parse_state;
    logic [7:0]   held_side;
    logic [7:0]   held_led;
    logic [7:0]   held_red;
    logic [7:0]   held_green;

    logic         in_taken = 1'b0;
    logic         activity = 1'b0;
    logic         jitter_en = 1'b1;
    logic         hold_req = 1'b0;
    int           hold_left = 0;
    int           tx_gap = 0;
    int           rx_gap = 0;
    int           fail_cnt = 0;
    int           quiet_cycles = 0;

    serial_framed_rgb_pwm_led_driver_top #(
        .LED_COUNT (LED_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [7:0] sat_decrement(input logic [7:0] raw);
        return (raw == COLOR_SAT) ? raw : raw - 8'd1;
    endfunction

    function automatic out_item_t pwm_frame_predict(input in_item_t item);
        out_item_t  res;
        logic [7:0] blue;
        logic [7:0] idx;
        logic       lvl;
        int         first_ch;
        res = '0;
        if (item.op == OP_TICK)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                lvl = (duty_mem[ch] <= tick_cnt);
                if (lvl != level_mem[ch])
                    res.changed_mask[ch] = 1'b1;
                level_mem[ch] = lvl;
            end
            tick_cnt = tick_cnt + 8'd1;
        end
        else
        begin
            case (parse_state)
                PH_EDGE:
                begin
                    held_side   = item.rx_byte - 8'd1;
                    parse_state = PH_LED;
                end
                PH_LED:
                begin
                    held_led    = item.rx_byte - 8'd1;
                    parse_state = PH_RED;
                end
                PH_RED:
                begin
                    held_red    = sat_decrement(item.rx_byte);
                    parse_state = PH_GREEN;
                end
                PH_GREEN:
                begin
                    held_green  = sat_decrement(item.rx_byte);
                    parse_state = PH_BLUE;
                end
                PH_BLUE:
                begin
                    blue = sat_decrement(item.rx_byte);
                    idx  = 8'd0;
                    if (held_side < EDGE_COUNT)
                        idx = edge_base[held_side[1:0]] + held_led;
                    if (idx < LED_COUNT)
                    begin
                        first_ch               = idx * COLORS_PER_LED;
                        duty_mem[first_ch]     = held_red;
                        duty_mem[first_ch + 1] = held_green;
                        duty_mem[first_ch + 2] = blue;
                        res.frame_written      = 1'b1;
                    end
                    else
                    begin
                        res.frame_dropped = 1'b1;
                    end
                    parse_state = PH_PREAMBLE;
                end
                default:
                begin
                    parse_state = (item.rx_byte == PREAMBLE) ? PH_EDGE : PH_PREAMBLE;
                end
            endcase
        end
        for (int ch = 0; ch < CHANNELS; ch++)
            res.pin_levels[ch] = level_mem[ch];
        return res;
    endfunction

    task automatic note_failure(input string what, input logic [FIELD_W-1:0] want,
                                input logic [FIELD_W-1:0] got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t: mismatch in %s: expected %h, actual %h", $realtime, what, want, got);
    endtask

    function automatic void push_item(input logic op, input logic [7:0] value);
        in_item_t item;
        item.op      = op;
        item.rx_byte = value;
        pending_q.push_back(item);
    endfunction

    function automatic logic [7:0] rand_duty();
        int k;
        k = $urandom_range(0, 7);
        if (k == 0)
            return 8'd0;
        else if (k == 1)
            return 8'd1;
        else if (k == 2)
            return COLOR_SAT;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int push_random_frame();
        int         k;
        int         side;
        logic [7:0] target;
        k = $urandom_range(0, 9);
        push_item(OP_BYTE, PREAMBLE);
        if (k < 7)
        begin
            side   = $urandom_range(0, EDGE_COUNT - 1);
            target = 8'($urandom_range(0, LED_COUNT - 1));
            push_item(OP_BYTE, 8'(side + 1));
            push_item(OP_BYTE, target - edge_base[side] + 8'd1);
        end
        else if (k < 8)
        begin
            push_item(OP_BYTE, ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(5, 255)));
            push_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        else
        begin
            push_item(OP_BYTE, 8'($urandom_range(0, 255)));
            push_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        push_item(OP_BYTE, rand_duty());
        push_item(OP_BYTE, rand_duty());
        push_item(OP_BYTE, rand_duty());
        return 6;
    endfunction

    task automatic fill_random_phase(input int n);
        int done;
        int k;
        int cnt;
        done = 0;
        while (done < n)
        begin
            k = $urandom_range(0, 19);
            if (k < 10)
            begin
                done += push_random_frame();
            end
            else if (k < 17)
            begin
                cnt = $urandom_range(1, 12);
                repeat (cnt) push_item(OP_TICK, 8'($urandom_range(0, 255)));
                done += cnt;
            end
            else if (k < 19)
            begin
                cnt = $urandom_range(1, 3);
                repeat (cnt) push_item(OP_BYTE, 8'($urandom_range(1, 255)));
                done += cnt;
            end
            else
            begin
                cnt = $urandom_range(1, 4);
                push_item(OP_BYTE, PREAMBLE);
                repeat (cnt) push_item(OP_BYTE, 8'($urandom_range(0, 255)));
                done += cnt + 1;
            end
        end
    endtask

    task automatic write_edge_base(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || expected_led_q.size() != 0 || in_valid);
        repeat (3) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (jitter_en && $urandom_range(0, 5) == 0)
            begin
                tx_gap = $urandom_range(0, 5);
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                in_data  <= pending_q[0];
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_stall <= 1'b1;
        end
        else if (jitter_en && $urandom_range(0, 5) == 0)
        begin
            rx_gap = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            activity = 1'b1;
            if (expected_led_q.size() == 0)
            begin
                note_failure("unexpected transaction", '0, out_data.pin_levels);
            end
            else
            begin
                want = expected_led_q.pop_front();
                if (out_data.pin_levels !== want.pin_levels)
                    note_failure("pin_levels", want.pin_levels, out_data.pin_levels);
                if (out_data.changed_mask !== want.changed_mask)
                    note_failure("changed_mask", want.changed_mask, out_data.changed_mask);
                if (out_data.frame_written !== want.frame_written)
                    note_failure("frame_written", want.frame_written, out_data.frame_written);
                if (out_data.frame_dropped !== want.frame_dropped)
                    note_failure("frame_dropped", want.frame_dropped, out_data.frame_dropped);
            end
        end
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
        begin
            activity = 1'b1;
            expected_led_q.push_back(pwm_frame_predict(in_data));
            pending_q.delete(0);
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            activity = 1'b1;
            if (cfg_index < EDGE_COUNT)
                edge_base[cfg_index[1:0]] = cfg_data;
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if (activity)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            activity = 1'b0;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        edge_base[0] = BASE_TOP_RESET;
        edge_base[1] = BASE_BOTTOM_RESET;
        edge_base[2] = BASE_LEFT_RESET;
        edge_base[3] = BASE_RIGHT_RESET;
        tick_cnt     = 8'd0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            duty_mem[ch]  = 8'd0;
            level_mem[ch] = 1'b0;
        end
        parse_state = PH_PREAMBLE;
        held_side   = 8'd0;
        held_led    = 8'd0;
        held_red    = 8'd0;
        held_green  = 8'd0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A write to an index past the last base register must be ignored.
        write_edge_base(CFG_BASE_RIGHT + 8'd1, 8'hFF);
        @(posedge clk);

        push_item(OP_BYTE, 8'hFF);
        push_item(OP_TICK, 8'hA5);
        // Top edge, first LED: duties 0, saturated 255, and 0 wrapping to 255.
        push_item(OP_BYTE, PREAMBLE);
        push_item(OP_BYTE, 8'd1);
        push_item(OP_BYTE, 8'd1);
        push_item(OP_BYTE, 8'd1);
        push_item(OP_BYTE, COLOR_SAT);
        push_item(OP_BYTE, 8'd0);
        // An unknown edge lands on LED 0.
        push_item(OP_BYTE, PREAMBLE);
        push_item(OP_BYTE, 8'd0);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, 8'h80);
        push_item(OP_BYTE, 8'h02);
        push_item(OP_BYTE, 8'hFE);
        // Right edge reaching the last LED.
        push_item(OP_BYTE, PREAMBLE);
        push_item(OP_BYTE, 8'd4);
        push_item(OP_BYTE, 8'd8);
        push_item(OP_BYTE, 8'h10);
        push_item(OP_BYTE, 8'h20);
        push_item(OP_BYTE, 8'h30);
        // Left edge one past the last LED is dropped.
        push_item(OP_BYTE, PREAMBLE);
        push_item(OP_BYTE, 8'd3);
        push_item(OP_BYTE, 8'd1);
        push_item(OP_BYTE, 8'h55);
        push_item(OP_BYTE, 8'h66);
        push_item(OP_BYTE, 8'h77);
        push_item(OP_TICK, 8'h5A);
        push_item(OP_TICK, 8'h00);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                for (int r = 0; r < EDGE_COUNT; r++)
                begin
                    case (p)
                        1: write_edge_base(BASE_REG[r], 8'd0);
                        2: write_edge_base(BASE_REG[r], 8'hFF);
                        3: write_edge_base(BASE_REG[r], 8'($urandom_range(0, 15)));
                        4: write_edge_base(BASE_REG[r], 8'($urandom_range(0, 255)));
                        default: write_edge_base(BASE_REG[r],
                                                 8'($urandom_range(0, LED_COUNT - 1)));
                    endcase
                end
                write_edge_base(8'(EDGE_COUNT + $urandom_range(0, 255 - EDGE_COUNT)),
                                8'($urandom_range(0, 255)));
            end
            @(posedge clk);
            if (p == 2)
                hold_req = 1'b1;
            if (p == PHASE_COUNT - 1)
                jitter_en = 1'b0;
            fill_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (fail_cnt == 0 && expected_led_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
